// ===== rtl/mie_pkg.sv =====
// Shared constants, opcode codes and the data memory request type.
package mie_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int LANES     = 4;
    localparam int ROWS      = MEM_BYTES / LANES;
    localparam int ROW_AW    = MEM_AW - 2;

    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_XORI  = 6'h0E;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LH    = 6'h21;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_LBU   = 6'h24;
    localparam logic [5:0] OP_LHU   = 6'h25;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // size is the byte count minus one: byte 0, half 1, word 3
    typedef struct packed {
        logic              en;
        logic              we;
        logic [1:0]        size;
        logic [MEM_AW-1:0] addr;
        logic [31:0]       wdata;
    } mie_dmem_req_t;

endpackage

// ===== rtl/mie_dmem.sv =====
// Byte-lane data memory with unaligned access steering and a clearing pass after reset.
module mie_dmem
    import mie_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  mie_dmem_req_t req,
    output logic [31:0]   rdata,
    output logic          clr_busy
);

    logic              clr_busy_reg;
    logic [ROW_AW-1:0] clr_row_reg;
    logic [1:0]        lo;
    logic [ROW_AW-1:0] row_base;
    logic [1:0]        lo_reg;
    logic [31:0]       lane_rd;
    logic [63:0]       rot;

    assign lo       = req.addr[1:0];
    assign row_base = req.addr[MEM_AW-1:2];
    assign clr_busy = clr_busy_reg;

    // sweep every row once, all lanes in parallel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_row_reg == ROW_AW'(ROWS - 1))
                clr_busy_reg <= 1'b0;
            clr_row_reg <= clr_row_reg + ROW_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
            lo_reg <= lo;
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        localparam logic [1:0] K = 2'(k);
        logic [7:0]        lane_mem [ROWS];
        logic [7:0]        rd_reg;
        logic [1:0]        pos;
        logic [ROW_AW-1:0] row;
        logic [31:0]       wshift;
        logic              we;
        logic [ROW_AW-1:0] waddr;
        logic [7:0]        wbyte;

        // byte pos of the access lands in this lane; lanes below lo wrap to the next row
        assign pos    = K - lo;
        assign row    = row_base + ROW_AW'(K < lo);
        assign wshift = req.wdata >> {pos, 3'b000};
        assign we     = clr_busy_reg || (req.en && req.we && (pos <= req.size));
        assign waddr  = clr_busy_reg ? clr_row_reg : row;
        assign wbyte  = clr_busy_reg ? 8'h00 : wshift[7:0];

        always_ff @(posedge clk)
        begin
            if (we)
                lane_mem[waddr] <= wbyte;
            if (req.en)
                rd_reg <= lane_mem[row];
        end

        assign lane_rd[8*k +: 8] = rd_reg;
    end

    // rotate lanes back so the byte at the access address lands in bits 7:0
    assign rot   = {lane_rd, lane_rd} >> {lo_reg, 3'b000};
    assign rdata = rot[31:0];

endmodule

// ===== rtl/mips_itype_execute.sv =====
// Pipeline: an input transfer moves through stage 1 and stage 2 into the output register,
// where the result stays until its output transfer. Throughput: one instruction per cycle unless
// out_ready stalls; data memory is touched once per instruction, the register file read at
// input and written from stage 2, with stage-2 forwarding and write-edge capture into stage 1.
// Reset: pipeline empties at once; in_ready stays low while the data memory is swept to zero;
// register file entries read zero until first written.
module mips_itype_execute
    import mie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instr_word,
    input  logic [31:0] cur_pc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_pc,
    output logic        branch_taken,
    output logic        reg_written,
    output logic [4:0]  dest_index,
    output logic [31:0] dest_value,
    output logic        mem_written,
    output logic        bad_opcode
);

    // register file
    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic        rf_we;

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic out_free, s2_en, s1_en, in_fire, s1_move;
    logic clr_busy;

    // stage 1
    logic [31:0] s1_instr_reg, s1_pc_reg;
    logic [31:0] rs_rd_reg, rt_rd_reg, rs_byp_reg, rt_byp_reg;
    logic        rs_ok_reg, rt_ok_reg, rs_hit_reg, rt_hit_reg;
    logic [5:0]  s1_op;
    logic [4:0]  s1_rs, s1_rt;
    logic [31:0] s1_simm, s1_a, s1_b, s1_eff;
    logic [31:0] rs_base, rt_base;
    mie_dmem_req_t dreq;
    logic [31:0] ld_word;

    // stage 2
    logic [5:0]  s2_op_reg;
    logic [4:0]  s2_rt_reg;
    logic [15:0] s2_imm_reg;
    logic [31:0] s2_a_reg, s2_b_reg, s2_pc_reg;
    logic [31:0] s2_simm, s2_val, s2_npc;
    logic        s2_wr, s2_wr_ok, s2_taken, s2_memw, s2_bad;

    // output register
    logic [31:0] npc_reg, dval_reg;
    logic        taken_reg, rw_reg, memw_reg, bad_reg;
    logic [4:0]  didx_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || out_free;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en && !clr_busy;
    assign in_fire  = in_valid && in_ready;
    assign s1_move  = s1_valid_reg && s2_en;
    assign rf_we    = s2_valid_reg && out_free && s2_wr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_fire;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
            if (rf_we)
                rf_valid_reg[s2_rt_reg] <= 1'b1;
        end
    end

    // register file: one write from stage 2, two reads for the incoming item
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[s2_rt_reg] <= s2_val;
        if (in_fire)
        begin
            rs_rd_reg <= rf_mem[instr_word[25:21]];
            rt_rd_reg <= rf_mem[instr_word[20:16]];
        end
    end

    // stage 1 payload; capture a write landing on the same edge as the read
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_instr_reg <= instr_word;
            s1_pc_reg    <= cur_pc;
            rs_ok_reg    <= rf_valid_reg[instr_word[25:21]];
            rt_ok_reg    <= rf_valid_reg[instr_word[20:16]];
            rs_hit_reg   <= rf_we && (s2_rt_reg == instr_word[25:21]);
            rt_hit_reg   <= rf_we && (s2_rt_reg == instr_word[20:16]);
            rs_byp_reg   <= s2_val;
            rt_byp_reg   <= s2_val;
        end
    end

    assign s1_op   = s1_instr_reg[31:26];
    assign s1_rs   = s1_instr_reg[25:21];
    assign s1_rt   = s1_instr_reg[20:16];
    assign s1_simm = {{16{s1_instr_reg[15]}}, s1_instr_reg[15:0]};

    always_comb
    begin
        rs_base = rs_hit_reg ? rs_byp_reg : (rs_ok_reg ? rs_rd_reg : 32'd0);
        rt_base = rt_hit_reg ? rt_byp_reg : (rt_ok_reg ? rt_rd_reg : 32'd0);
        // forward from the older instruction still in stage 2
        if (s2_valid_reg && s2_wr_ok && (s2_rt_reg == s1_rs))
            s1_a = s2_val;
        else
            s1_a = rs_base;
        if (s2_valid_reg && s2_wr_ok && (s2_rt_reg == s1_rt))
            s1_b = s2_val;
        else
            s1_b = rt_base;
    end

    assign s1_eff = s1_a + s1_simm;

    // loads read and stores write on the same edge, so memory order follows program order
    always_comb
    begin
        dreq.en    = s1_move;
        dreq.we    = (s1_op == OP_SB) || (s1_op == OP_SH) || (s1_op == OP_SW);
        dreq.size  = s1_op[1:0];
        dreq.addr  = s1_eff[MEM_AW-1:0];
        dreq.wdata = s1_b;
    end

    mie_dmem u_dmem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .rdata    (ld_word),
        .clr_busy (clr_busy)
    );

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_op_reg  <= s1_op;
            s2_rt_reg  <= s1_rt;
            s2_imm_reg <= s1_instr_reg[15:0];
            s2_a_reg   <= s1_a;
            s2_b_reg   <= s1_b;
            s2_pc_reg  <= s1_pc_reg;
        end
    end

    assign s2_simm = {{16{s2_imm_reg[15]}}, s2_imm_reg};

    always_comb
    begin
        s2_val   = 32'd0;
        s2_wr    = 1'b0;
        s2_taken = 1'b0;
        s2_memw  = 1'b0;
        s2_bad   = 1'b0;
        case (s2_op_reg)
            OP_ADDI, OP_ADDIU:
            begin
                s2_val = s2_a_reg + s2_simm;
                s2_wr  = 1'b1;
            end
            OP_SLTI:
            begin
                s2_val = {31'd0, $signed(s2_a_reg) < $signed(s2_simm)};
                s2_wr  = 1'b1;
            end
            OP_SLTIU:
            begin
                s2_val = {31'd0, s2_a_reg < s2_simm};
                s2_wr  = 1'b1;
            end
            OP_ANDI:
            begin
                s2_val = s2_a_reg & {16'd0, s2_imm_reg};
                s2_wr  = 1'b1;
            end
            OP_ORI:
            begin
                s2_val = s2_a_reg | {16'd0, s2_imm_reg};
                s2_wr  = 1'b1;
            end
            OP_XORI:
            begin
                s2_val = s2_a_reg ^ {16'd0, s2_imm_reg};
                s2_wr  = 1'b1;
            end
            OP_LUI:
            begin
                s2_val = {s2_imm_reg, 16'd0};
                s2_wr  = 1'b1;
            end
            OP_BEQ:
                s2_taken = (s2_a_reg == s2_b_reg);
            OP_BNE:
                s2_taken = (s2_a_reg != s2_b_reg);
            OP_LB:
            begin
                s2_val = {{24{ld_word[7]}}, ld_word[7:0]};
                s2_wr  = 1'b1;
            end
            OP_LBU:
            begin
                s2_val = {24'd0, ld_word[7:0]};
                s2_wr  = 1'b1;
            end
            OP_LH:
            begin
                s2_val = {{16{ld_word[15]}}, ld_word[15:0]};
                s2_wr  = 1'b1;
            end
            OP_LHU:
            begin
                s2_val = {16'd0, ld_word[15:0]};
                s2_wr  = 1'b1;
            end
            OP_LW:
            begin
                s2_val = ld_word;
                s2_wr  = 1'b1;
            end
            OP_SB, OP_SH, OP_SW:
                s2_memw = 1'b1;
            default:
                s2_bad = 1'b1;
        endcase
    end

    // a write to register zero is dropped
    assign s2_wr_ok = s2_wr && (s2_rt_reg != 5'd0);
    assign s2_npc   = s2_pc_reg + 32'd4 + (s2_taken ? {s2_simm[29:0], 2'b00} : 32'd0);

    always_ff @(posedge clk)
    begin
        if (out_free && s2_valid_reg)
        begin
            npc_reg   <= s2_npc;
            taken_reg <= s2_taken;
            rw_reg    <= s2_wr_ok;
            didx_reg  <= s2_wr_ok ? s2_rt_reg : 5'd0;
            dval_reg  <= s2_wr_ok ? s2_val : 32'd0;
            memw_reg  <= s2_memw;
            bad_reg   <= s2_bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = npc_reg;
    assign branch_taken = taken_reg;
    assign reg_written  = rw_reg;
    assign dest_index   = didx_reg;
    assign dest_value   = dval_reg;
    assign mem_written  = memw_reg;
    assign bad_opcode   = bad_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !in_fire)
        else $error("input transfer during memory clear");

    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (s2_rt_reg != 5'd0))
        else $error("register zero written");

    a_store_no_regwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && dreq.we) |=> (s2_valid_reg && !s2_wr_ok))
        else $error("store also writes a register");

    a_bad_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_reg) |-> (!rw_reg && !memw_reg && !taken_reg))
        else $error("unknown opcode changed state");

endmodule
